>>> design/rtcsm_pkg.sv
`timescale 1ns / 1ps

package rtcsm_pkg;

   localparam int BURST_BYTES = 8;
   localparam int BYTE_IDX_W  = $clog2(BURST_BYTES + 1);

   localparam int CSR_W       = 10;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_BIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP    = 1'b1;

   localparam logic [CSR_W-1:0] HALF_BIT_RESET = 10'd2;
   localparam logic [CSR_W-1:0] SETUP_RESET    = 10'd20;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_BURST = 2'd3;

   localparam logic [1:0] FMT_RAW  = 2'd0;

   localparam logic [7:0] CMD_SECONDS = 8'h81;
   localparam logic [7:0] CMD_BURST   = 8'hBF;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SETUP = 3'd1,
      PH_WLOW  = 3'd2,
      PH_WHIGH = 3'd3,
      PH_GAP   = 3'd4,
      PH_RHIGH = 3'd5,
      PH_RLOW  = 3'd6,
      PH_END   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] cmd;
      logic [7:0] wdata;
      logic [1:0] fmt;
      logic       io_in;
   } req_type;

   typedef struct packed {
      logic       ce;
      logic       sclk;
      logic       io_out;
      logic       io_drive;
      logic [7:0] rdata;
      logic       rdata_valid;
      logic       last;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic                 we;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_W-1:0]     wdata;
   } csr_write_type;

endpackage

>>> design/rtcsm_format.sv
`timescale 1ns / 1ps

module rtcsm_format (
   input  logic [7:0] raw_byte,
   input  logic [1:0] lop,
   input  logic [1:0] lfmt,
   input  logic [7:0] lcmd,
   input  logic       first_byte,
   output logic [7:0] rdata
);

   logic       secs;
   logic [7:0] masked;

   always_comb begin
      secs = ((lop == rtcsm_pkg::OP_READ) && (lcmd == rtcsm_pkg::CMD_SECONDS))
          || ((lop == rtcsm_pkg::OP_BURST) && first_byte);
      masked = ((lfmt != rtcsm_pkg::FMT_RAW) && secs) ? {1'b0, raw_byte[6:0]} : raw_byte;
      if (lfmt[1]) begin
         // high nibble times ten plus low nibble
         rdata = {1'b0, masked[7:4], 3'b000} + {3'b000, masked[7:4], 1'b0}
               + {4'b0000, masked[3:0]};
      end else begin
         rdata = masked;
      end
   end

endmodule

>>> design/rtcsm_seq.sv
`timescale 1ns / 1ps

module rtcsm_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  rtcsm_pkg::req_type        req,
   input  rtcsm_pkg::csr_write_type  csr,
   output rtcsm_pkg::rsp_type        rsp
);

   localparam int BW = rtcsm_pkg::BYTE_IDX_W;

   rtcsm_pkg::phase_type phase_ff, phase_in;
   logic [9:0]    tick_ff, tick_in;
   logic [2:0]    bit_ff, bit_in;
   logic [BW-1:0] byte_ff, byte_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    lcmd_ff, lcmd_in;
   logic [7:0]    lwdata_ff, lwdata_in;
   logic [1:0]    lop_ff, lop_in;
   logic [1:0]    lfmt_ff, lfmt_in;
   logic [9:0]    half_bit_ff, setup_ff;

   logic [9:0]    len;
   logic          cnt_done;
   logic [9:0]    cnt_next;
   logic [7:0]    rd_shifted;
   logic [2:0]    bit_next;
   logic [BW-1:0] byte_inc;
   logic [7:0]    fmt_byte;

   rtcsm_format u_format (
      .raw_byte   (rd_shifted),
      .lop        (lop_ff),
      .lfmt       (lfmt_ff),
      .lcmd       (lcmd_ff),
      .first_byte (byte_ff == '0),
      .rdata      (fmt_byte)
   );

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      shift_in  = shift_ff;
      lcmd_in   = lcmd_ff;
      lwdata_in = lwdata_ff;
      lop_in    = lop_ff;
      lfmt_in   = lfmt_ff;
      rsp       = '0;
      rsp.busy_res = (phase_ff != rtcsm_pkg::PH_IDLE);

      unique case (phase_ff)
         rtcsm_pkg::PH_SETUP, rtcsm_pkg::PH_GAP, rtcsm_pkg::PH_END: len = setup_ff;
         default: len = half_bit_ff;
      endcase
      // a zero length still ends after one tick
      cnt_done   = ({1'b0, tick_ff} + 11'd1) >= {1'b0, len};
      cnt_next   = cnt_done ? 10'd0 : tick_ff + 10'd1;
      rd_shifted = {req.io_in, shift_ff[7:1]};
      bit_next   = bit_ff + 3'd1;
      byte_inc   = byte_ff + BW'(1);

      unique case (phase_ff)
         rtcsm_pkg::PH_IDLE: ;
         rtcsm_pkg::PH_SETUP: begin
            rsp.ce = 1'b1;
            rsp.io_drive = 1'b1;
         end
         rtcsm_pkg::PH_WLOW: begin
            rsp.ce = 1'b1;
            rsp.io_drive = 1'b1;
            rsp.io_out = shift_ff[0];
         end
         rtcsm_pkg::PH_WHIGH, rtcsm_pkg::PH_GAP: begin
            rsp.ce = 1'b1;
            rsp.sclk = 1'b1;
            rsp.io_drive = 1'b1;
            rsp.io_out = shift_ff[0];
         end
         rtcsm_pkg::PH_RHIGH, rtcsm_pkg::PH_END: begin
            rsp.ce = 1'b1;
            rsp.sclk = 1'b1;
         end
         rtcsm_pkg::PH_RLOW: begin
            rsp.ce = 1'b1;
         end
      endcase

      if (step) begin
         unique case (phase_ff)
            rtcsm_pkg::PH_IDLE: begin
               if (req.op != rtcsm_pkg::OP_NONE) begin
                  lcmd_in   = req.cmd;
                  lwdata_in = req.wdata;
                  lop_in    = req.op;
                  lfmt_in   = req.fmt;
                  shift_in  = (req.op == rtcsm_pkg::OP_BURST) ? rtcsm_pkg::CMD_BURST : req.cmd;
                  bit_in    = 3'd0;
                  byte_in   = '0;
                  tick_in   = 10'd0;
                  phase_in  = rtcsm_pkg::PH_SETUP;
               end
            end
            rtcsm_pkg::PH_SETUP, rtcsm_pkg::PH_GAP: begin
               tick_in = cnt_next;
               if (cnt_done) phase_in = rtcsm_pkg::PH_WLOW;
            end
            rtcsm_pkg::PH_WLOW: begin
               tick_in = cnt_next;
               if (cnt_done) phase_in = rtcsm_pkg::PH_WHIGH;
            end
            rtcsm_pkg::PH_WHIGH: begin
               tick_in = cnt_next;
               if (cnt_done) begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  bit_in   = bit_next;
                  priority if (bit_next != 3'd0) begin
                     phase_in = rtcsm_pkg::PH_WLOW;
                  end else if (lop_ff == rtcsm_pkg::OP_WRITE && byte_ff == '0) begin
                     byte_in  = BW'(1);
                     shift_in = lwdata_ff;
                     phase_in = rtcsm_pkg::PH_GAP;
                  end else if (lop_ff == rtcsm_pkg::OP_WRITE) begin
                     phase_in = rtcsm_pkg::PH_END;
                  end else begin
                     byte_in  = '0;
                     shift_in = 8'd0;
                     phase_in = rtcsm_pkg::PH_RHIGH;
                  end
               end
            end
            rtcsm_pkg::PH_RHIGH: begin
               tick_in = cnt_next;
               if (cnt_done) phase_in = rtcsm_pkg::PH_RLOW;
            end
            rtcsm_pkg::PH_RLOW: begin
               tick_in = cnt_next;
               if (cnt_done) begin
                  shift_in = rd_shifted;
                  bit_in   = bit_next;
                  phase_in = rtcsm_pkg::PH_RHIGH;
                  if (bit_next == 3'd0) begin
                     rsp.rdata_valid = 1'b1;
                     rsp.rdata       = fmt_byte;
                     byte_in         = byte_inc;
                     if (lop_ff != rtcsm_pkg::OP_BURST
                         || byte_inc >= BW'(rtcsm_pkg::BURST_BYTES)) begin
                        rsp.last = 1'b1;
                        phase_in = rtcsm_pkg::PH_END;
                     end
                     shift_in = 8'd0;
                  end
               end
            end
            rtcsm_pkg::PH_END: begin
               tick_in = cnt_next;
               if (cnt_done) phase_in = rtcsm_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rtcsm_pkg::PH_IDLE;
         tick_ff     <= '0;
         bit_ff      <= '0;
         byte_ff     <= '0;
         shift_ff    <= '0;
         lcmd_ff     <= '0;
         lwdata_ff   <= '0;
         lop_ff      <= '0;
         lfmt_ff     <= '0;
         half_bit_ff <= rtcsm_pkg::HALF_BIT_RESET;
         setup_ff    <= rtcsm_pkg::SETUP_RESET;
      end else begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         shift_ff  <= shift_in;
         lcmd_ff   <= lcmd_in;
         lwdata_ff <= lwdata_in;
         lop_ff    <= lop_in;
         lfmt_ff   <= lfmt_in;
         if (csr.we && csr.index == rtcsm_pkg::CSR_HALF_BIT) half_bit_ff <= csr.wdata;
         if (csr.we && csr.index == rtcsm_pkg::CSR_SETUP) setup_ff <= csr.wdata;
      end
   end

endmodule

>>> design/three_wire_rtc_serial_master_unit.sv
// path: an accepted transaction is held in the input register, then the sequencer step
//   writes its result into the result register, where it is offered until it is taken
// throughput: one transaction per cycle while results are not stalled, set by the single
//   sequencer step between the input register and the result register
// reset: synchronous, active high; clears the handshake stages, the sequencer
//   state and restores half_bit_ticks to 2 and setup_ticks to 20
`timescale 1ns / 1ps

module three_wire_rtc_serial_master_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rtcsm_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rtcsm_pkg::rsp_type                  rsp_payload,
   input  logic                                csr_we,
   input  logic [rtcsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rtcsm_pkg::CSR_W-1:0]         csr_wdata
);

   logic                    in_valid_ff;
   rtcsm_pkg::req_type      in_item_ff;
   logic                    out_valid_ff;
   rtcsm_pkg::rsp_type      out_item_ff;
   logic                    advance;
   rtcsm_pkg::rsp_type      step_rsp;
   rtcsm_pkg::csr_write_type csr;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr       = '{we: csr_we, index: csr_index, wdata: csr_wdata};

   rtcsm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_item_ff),
      .csr   (csr),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_payload;
      if (advance) out_item_ff <= step_rsp;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

>>> design/rtcsm_checker.sv
`timescale 1ns / 1ps

module rtcsm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rtcsm_pkg::rsp_type rsp_payload
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_released_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.io_drive |-> !rsp_payload.io_out)
      else $error("io_out high while released");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.rdata_valid |-> rsp_payload.rdata == 8'd0 && !rsp_payload.last)
      else $error("byte fields set without a byte");

   a_pins_need_ce: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.sclk || rsp_payload.io_drive) |-> rsp_payload.ce)
      else $error("sclk or drive without chip enable");

   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.busy_res |-> !rsp_payload.ce && !rsp_payload.rdata_valid)
      else $error("pins active while idle");

endmodule

bind three_wire_rtc_serial_master_unit rtcsm_checker u_rtcsm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

>>> tb/rtc_pin_checker.sv
`timescale 1ns / 1ps

module rtc_pin_checker
   import rtcsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_payload,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   pending
);

   phase_type        seq_phase;
   logic [CSR_W-1:0] tick_cnt;
   logic [2:0]       bit_cnt;
   logic [4:0]       byte_cnt;
   logic [7:0]       shifter;
   logic [7:0]       held_cmd;
   logic [7:0]       held_wdata;
   logic [1:0]       held_op;
   logic [1:0]       held_fmt;
   logic [CSR_W-1:0] half_bit;
   logic [CSR_W-1:0] setup_len;
   rsp_type          pin_forecast[$];
   rsp_type          next_pins;
   int               errs = 0;

   function automatic logic count_done(input logic [CSR_W-1:0] len);
      int span;
      span = (len == 0) ? 1 : int'(len);
      if (int'(tick_cnt) + 1 >= span) begin
         tick_cnt = '0;
         return 1'b1;
      end
      tick_cnt = tick_cnt + 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [7:0] shape_byte(input logic [7:0] raw);
      logic [7:0] d;
      logic       seconds;
      d = raw;
      seconds = (held_op == OP_READ && held_cmd == CMD_SECONDS) ||
                (held_op == OP_BURST && byte_cnt == 0);
      if (held_fmt != FMT_RAW && seconds) d[7] = 1'b0;
      if (held_fmt[1]) d = d[7:4] * 8'd10 + d[3:0];
      return d;
   endfunction

   task automatic advance_sequencer(input req_type item, output rsp_type pins);
      pins = '0;
      pins.busy_res = (seq_phase != PH_IDLE);
      case (seq_phase)
         PH_SETUP: begin
            pins.ce = 1'b1;
            pins.io_drive = 1'b1;
         end
         PH_WLOW: begin
            pins.ce = 1'b1;
            pins.io_drive = 1'b1;
            pins.io_out = shifter[0];
         end
         PH_WHIGH, PH_GAP: begin
            pins.ce = 1'b1;
            pins.sclk = 1'b1;
            pins.io_drive = 1'b1;
            pins.io_out = shifter[0];
         end
         PH_RHIGH, PH_END: begin
            pins.ce = 1'b1;
            pins.sclk = 1'b1;
         end
         PH_RLOW: pins.ce = 1'b1;
         default: ;
      endcase

      case (seq_phase)
         PH_IDLE: begin
            if (item.op != OP_NONE) begin
               held_cmd = item.cmd;
               held_wdata = item.wdata;
               held_op = item.op;
               held_fmt = item.fmt;
               shifter = (item.op == OP_BURST) ? CMD_BURST : item.cmd;
               bit_cnt = '0;
               byte_cnt = '0;
               tick_cnt = '0;
               seq_phase = PH_SETUP;
            end
         end
         PH_SETUP, PH_GAP: begin
            if (count_done(setup_len)) seq_phase = PH_WLOW;
         end
         PH_WLOW: begin
            if (count_done(half_bit)) seq_phase = PH_WHIGH;
         end
         PH_WHIGH: begin
            if (count_done(half_bit)) begin
               shifter = shifter >> 1;
               bit_cnt = bit_cnt + 1'b1;
               if (bit_cnt != 0) begin
                  seq_phase = PH_WLOW;
               end else if (held_op == OP_WRITE && byte_cnt == 0) begin
                  byte_cnt = 5'd1;
                  shifter = held_wdata;
                  seq_phase = PH_GAP;
               end else if (held_op == OP_WRITE) begin
                  seq_phase = PH_END;
               end else begin
                  byte_cnt = '0;
                  shifter = '0;
                  seq_phase = PH_RHIGH;
               end
            end
         end
         PH_RHIGH: begin
            if (count_done(half_bit)) seq_phase = PH_RLOW;
         end
         PH_RLOW: begin
            if (count_done(half_bit)) begin
               shifter = {item.io_in, shifter[7:1]};
               bit_cnt = bit_cnt + 1'b1;
               seq_phase = PH_RHIGH;
               if (bit_cnt == 0) begin
                  pins.rdata_valid = 1'b1;
                  pins.rdata = shape_byte(shifter);
                  byte_cnt = byte_cnt + 1'b1;
                  if (held_op != OP_BURST || byte_cnt >= BURST_BYTES) begin
                     pins.last = 1'b1;
                     seq_phase = PH_END;
                  end
                  shifter = '0;
               end
            end
         end
         PH_END: begin
            if (count_done(setup_len)) seq_phase = PH_IDLE;
         end
         default: begin
            seq_phase = PH_IDLE;
            tick_cnt = '0;
         end
      endcase
   endtask

   task automatic note_mismatch(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      errs++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   task automatic compare_pins(input rsp_type got);
      rsp_type want;
      if (pin_forecast.size() == 0) begin
         errs++;
         $display("%0t: transaction with nothing awaited, expected none, actual %h",
                  $time, got);
         return;
      end
      want = pin_forecast.pop_front();
      if (got.ce !== want.ce) note_mismatch("ce", 8'(want.ce), 8'(got.ce));
      if (got.sclk !== want.sclk) note_mismatch("sclk", 8'(want.sclk), 8'(got.sclk));
      if (got.io_out !== want.io_out)
         note_mismatch("io_out", 8'(want.io_out), 8'(got.io_out));
      if (got.io_drive !== want.io_drive)
         note_mismatch("io_drive", 8'(want.io_drive), 8'(got.io_drive));
      if (got.rdata !== want.rdata) note_mismatch("rdata", want.rdata, got.rdata);
      if (got.rdata_valid !== want.rdata_valid)
         note_mismatch("rdata_valid", 8'(want.rdata_valid), 8'(got.rdata_valid));
      if (got.last !== want.last) note_mismatch("last", 8'(want.last), 8'(got.last));
      if (got.busy_res !== want.busy_res)
         note_mismatch("busy_res", 8'(want.busy_res), 8'(got.busy_res));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         seq_phase = PH_IDLE;
         tick_cnt = '0;
         bit_cnt = '0;
         byte_cnt = '0;
         shifter = '0;
         held_cmd = '0;
         held_wdata = '0;
         held_op = '0;
         held_fmt = '0;
         half_bit = HALF_BIT_RESET;
         setup_len = SETUP_RESET;
         pin_forecast.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_pins(rsp_payload);
         if (req_valid && req_ready) begin
            advance_sequencer(req_payload, next_pins);
            pin_forecast.push_back(next_pins);
         end
         if (csr_we) begin
            if (csr_index == CSR_HALF_BIT) half_bit = csr_wdata;
            else if (csr_index == CSR_SETUP) setup_len = csr_wdata;
         end
      end
      pending <= pin_forecast.size();
      mismatches <= errs;
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rtcsm_pkg::*;

   localparam logic [1:0] FMT_MASK       = 2'd1;
   localparam logic [1:0] FMT_DECODE     = 2'd2;
   localparam logic [1:0] FMT_DECODE_ALT = 2'd3;
   localparam int IO_LOW       = 0;
   localparam int IO_HIGH      = 1;
   localparam int IO_RANDOM    = 2;
   localparam int QUIET_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 8;
   localparam int PHASE_ITEMS  = 60;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HALF_BIT;
   logic [CSR_W-1:0]     csr_wdata = '0;

   int idle_pct = 0;
   int stall_pct = 0;
   int quiet = 0;
   int items_sent = 0;
   int half_now = int'(HALF_BIT_RESET);
   int setup_now = int'(SETUP_RESET);
   int mismatches;
   int pending;

   three_wire_rtc_serial_master_unit dut (.*);

   rtc_pin_checker pin_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("three_wire_rtc_serial_master_unit test failed");
            $finish;
         end
      end
   end

   task automatic send_tick(input logic [1:0] op, input logic [7:0] cmd,
                            input logic [7:0] wd, input logic [1:0] fmt, input int io_mode);
      req_type item;
      item.op = op;
      item.cmd = cmd;
      item.wdata = wd;
      item.fmt = fmt;
      case (io_mode)
         IO_LOW:  item.io_in = 1'b0;
         IO_HIGH: item.io_in = 1'b1;
         default: item.io_in = 1'($urandom_range(1));
      endcase
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic retime(input int half, input int setup);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_HALF_BIT;
      csr_wdata <= CSR_W'(half);
      @(posedge clock);
      csr_index <= CSR_SETUP;
      csr_wdata <= CSR_W'(setup);
      @(posedge clock);
      csr_we <= 1'b0;
      half_now = half;
      setup_now = setup;
   endtask

   function automatic int busy_len(input logic [1:0] op, input int half, input int setup);
      int h;
      int s;
      int n;
      h = (half == 0) ? 1 : half;
      s = (setup == 0) ? 1 : setup;
      n = 2 * s + 16 * h;
      case (op)
         OP_WRITE: n += s + 16 * h;
         OP_READ:  n += 16 * h;
         OP_BURST: n += 16 * h * BURST_BYTES;
         default:  n = 0;
      endcase
      return n;
   endfunction

   task automatic run_txn(input logic [1:0] op, input logic [7:0] cmd, input logic [7:0] wd,
                          input logic [1:0] fmt, input int io_mode, input bit cut_in);
      int n;
      int cut;
      int old_half;
      int old_setup;
      n = busy_len(op, half_now, setup_now);
      cut = cut_in ? $urandom_range(n - 1, 1) : n;
      send_tick(op, cmd, wd, fmt, io_mode);
      // ops arriving while the sequencer is busy are ignored
      for (int i = 0; i < cut; i++)
         send_tick(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                   2'($urandom_range(3)), io_mode);
      if (cut_in) begin
         old_half = half_now;
         old_setup = setup_now;
         retime($urandom_range(2), $urandom_range(3));
         n = busy_len(op, (old_half > half_now) ? old_half : half_now,
                      (old_setup > setup_now) ? old_setup : setup_now);
         for (int i = 0; i < n; i++)
            send_tick(OP_NONE, 8'($urandom), 8'($urandom), 2'($urandom_range(3)), io_mode);
      end
   endtask

   task automatic random_phase(input int sender_idle, input int receiver_stall);
      int goal;
      int pick;
      logic [1:0] op;
      logic [7:0] cmd;
      int io_mode;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      retime($urandom_range(1), $urandom_range(2));
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            repeat ($urandom_range(6, 1))
               send_tick(OP_NONE, 8'($urandom), 8'($urandom), 2'($urandom_range(3)),
                         IO_RANDOM);
         end else begin
            pick = $urandom_range(99);
            op = (pick < 40) ? OP_READ : (pick < 78) ? OP_WRITE : OP_BURST;
            cmd = ($urandom_range(3) == 0) ? CMD_SECONDS : 8'($urandom);
            pick = $urandom_range(9);
            io_mode = (pick == 0) ? IO_LOW : (pick == 1) ? IO_HIGH : IO_RANDOM;
            run_txn(op, cmd, 8'($urandom), 2'($urandom_range(3)), io_mode,
                    $urandom_range(9) == 0);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset timing values, changed in the middle of the transaction
      run_txn(OP_READ, CMD_SECONDS, 8'h00, FMT_MASK, IO_HIGH, 1'b1);
      retime(1, 1);
      run_txn(OP_BURST, 8'h00, 8'h00, FMT_DECODE, IO_RANDOM, 1'b0);
      run_txn(OP_READ, 8'h83, 8'h00, FMT_DECODE_ALT, IO_HIGH, 1'b0);
      retime(0, 0);
      run_txn(OP_WRITE, 8'hA5, 8'h5A, FMT_RAW, IO_RANDOM, 1'b0);

      random_phase(0, 0);
      random_phase(63, 0);
      random_phase(0, 63);
      random_phase(12, 12);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("three_wire_rtc_serial_master_unit test passed");
      end else begin
         $display("three_wire_rtc_serial_master_unit test failed");
      end
      $finish;
   end

endmodule
